FILE: hdl/plsm_pkg.sv
// shared types and constants of the piecewise linear scaling map
`default_nettype none

package plsm_pkg;

  localparam int RAW_W       = 16;
  localparam int SCALED_W    = 32;
  localparam int CFG_W       = RAW_W + SCALED_W;
  // signed difference of two scaled values
  localparam int DIFF_W      = SCALED_W + 1;
  // signed product of a difference and an unsigned raw offset
  localparam int PROD_W      = DIFF_W + RAW_W + 1;
  // magnitude of that product
  localparam int NUM_W       = SCALED_W + RAW_W;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REGION_INTERP = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_t;

  typedef struct packed {
    logic        [RAW_W-1:0]    raw;
    logic signed [SCALED_W-1:0] scaled;
  } map_point_t;

  typedef struct packed {
    logic [RAW_W-1:0] sample;
    map_point_t       lo_pt;
    map_point_t       hi_pt;
    region_t          region;
  } job_t;

  typedef struct packed {
    logic signed [SCALED_W-1:0] base;
    region_t                    region;
    logic                       neg;
  } side_t;

endpackage

`default_nettype wire

FILE: hdl/plsm_front.sv
// front end: brackets a sample between two breakpoints and classifies it
`default_nettype none

module plsm_front #(
  parameter int MAP_POINTS = 5
) (
  input  logic [plsm_pkg::RAW_W-1:0] raw_sample,
  input  plsm_pkg::map_point_t       points [MAP_POINTS],
  output plsm_pkg::job_t             job
);

  import plsm_pkg::*;

  // highest breakpoint at or below the sample wins, breakpoint 0 by default
  always_comb begin
    job.sample = raw_sample;
    job.lo_pt  = points[0];
    job.hi_pt  = points[1];
    for (int i = 1; i < MAP_POINTS; i++) begin
      if (points[i].raw <= raw_sample) begin
        job.lo_pt = points[i];
        job.hi_pt = points[(i == MAP_POINTS - 1) ? i : i + 1];
      end
    end
    // lower point above the sample only when nothing matched and point 0 is above it
    if (points[MAP_POINTS-1].raw <= raw_sample) begin
      job.region = REGION_ABOVE;
    end else if (raw_sample < job.lo_pt.raw) begin
      job.region = REGION_BELOW;
    end else begin
      job.region = REGION_INTERP;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/plsm_queue.sv
// small register queue between front and back end
`default_nettype none

module plsm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/plsm_divider.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module plsm_divider #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              stage_valid [NUM_W];
  logic [DEN_W-1:0]  stage_rem   [NUM_W];
  logic [NUM_W-1:0]  stage_nq    [NUM_W];
  logic [DEN_W-1:0]  stage_den   [NUM_W];
  logic [SIDE_W-1:0] stage_side  [NUM_W];

  genvar k;
  for (k = 0; k < NUM_W; k++) begin : g_stage
    logic              src_valid;
    logic [DEN_W-1:0]  src_rem;
    logic [NUM_W-1:0]  src_nq;
    logic [DEN_W-1:0]  src_den;
    logic [SIDE_W-1:0] src_side;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_src
      assign src_valid = in_valid;
      assign src_rem   = '0;
      assign src_nq    = num;
      assign src_den   = den;
      assign src_side  = side;
    end else begin : g_src
      assign src_valid = stage_valid[k-1];
      assign src_rem   = stage_rem[k-1];
      assign src_nq    = stage_nq[k-1];
      assign src_den   = stage_den[k-1];
      assign src_side  = stage_side[k-1];
    end

    // numerator bits move out at the top, quotient bits come in at the bottom
    assign trial = {src_rem, src_nq[NUM_W-1]};
    assign fits  = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (en) begin
        stage_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_rem[k]  <= fits ? DEN_W'(trial - {1'b0, src_den}) : DEN_W'(trial);
        stage_nq[k]   <= {src_nq[NUM_W-2:0], fits};
        stage_den[k]  <= src_den;
        stage_side[k] <= src_side;
      end
    end
  end

  assign out_valid = stage_valid[NUM_W-1];
  assign quot      = stage_nq[NUM_W-1];
  assign out_side  = stage_side[NUM_W-1];

endmodule

`default_nettype wire

FILE: hdl/plsm_back.sv
// back end: span set-up, multiply, divide and final add with output register
`default_nettype none

module plsm_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  plsm_pkg::job_t                      job,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [plsm_pkg::SCALED_W-1:0] scaled_value,
  output plsm_pkg::region_t                   region
);

  import plsm_pkg::*;

  localparam int SIDE_W = $bits(side_t);

  logic adv;

  // stage a: offsets and span
  logic                     a_valid;
  logic signed [DIFF_W-1:0] a_diff;
  logic [RAW_W-1:0]         a_dx;
  logic [RAW_W-1:0]         a_span;
  side_t                    a_side;
  logic signed [DIFF_W-1:0] a_diff_next;
  logic [RAW_W-1:0]         a_dx_next;
  logic [RAW_W-1:0]         a_span_next;
  logic                     interp;

  // stage b: product
  logic                     b_valid;
  logic signed [PROD_W-1:0] b_prod;
  logic [RAW_W-1:0]         b_span;
  side_t                    b_side;

  // stage c: magnitude and sign
  logic                     c_valid;
  logic [NUM_W-1:0]         c_num;
  logic [RAW_W-1:0]         c_span;
  side_t                    c_side;
  side_t                    c_side_next;

  // divider result
  logic                     d_valid;
  logic [NUM_W-1:0]         d_quot;
  logic [SIDE_W-1:0]        d_side_bits;
  side_t                    d_side;

  // stage e: signed quotient
  logic                     e_valid;
  logic signed [DIFF_W-1:0] e_sq;
  side_t                    e_side;
  logic signed [DIFF_W-1:0] q_signed;

  // whole pipeline moves together unless a finished word is held
  assign adv       = !out_valid || out_ready;
  assign job_ready = adv;

  always_comb begin
    interp = (job.region == REGION_INTERP) && (job.hi_pt.raw > job.lo_pt.raw);
    if (interp) begin
      a_diff_next = {job.hi_pt.scaled[SCALED_W-1], job.hi_pt.scaled}
                  - {job.lo_pt.scaled[SCALED_W-1], job.lo_pt.scaled};
      a_dx_next   = job.sample - job.lo_pt.raw;
      a_span_next = job.hi_pt.raw - job.lo_pt.raw;
    end else begin
      a_diff_next = '0;
      a_dx_next   = '0;
      a_span_next = RAW_W'(1);
    end
  end

  always_comb begin
    c_side_next     = b_side;
    c_side_next.neg = b_prod[PROD_W-1];
  end

  assign d_side   = side_t'(d_side_bits);
  assign q_signed = $signed(d_quot[DIFF_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= job_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff        <= a_diff_next;
      a_dx          <= a_dx_next;
      a_span        <= a_span_next;
      a_side.base   <= job.lo_pt.scaled;
      a_side.region <= job.region;
      a_side.neg    <= 1'b0;

      b_prod        <= a_diff * $signed({1'b0, a_dx});
      b_span        <= a_span;
      b_side        <= a_side;

      c_num         <= NUM_W'(b_prod[PROD_W-1] ? -b_prod : b_prod);
      c_span        <= b_span;
      c_side        <= c_side_next;

      e_sq          <= d_side.neg ? -q_signed : q_signed;
      e_side        <= d_side;

      scaled_value  <= e_side.base + e_sq[SCALED_W-1:0];
      region        <= e_side.region;
    end
  end

  plsm_divider #(
    .NUM_W  (NUM_W),
    .DEN_W  (RAW_W),
    .SIDE_W (SIDE_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .num       (c_num),
    .den       (c_span),
    .side      (c_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .out_side  (d_side_bits)
  );

endmodule

`default_nettype wire

FILE: hdl/piecewise_linear_scaling_map.sv
// piecewise linear scaling map: calibration table, front end, queue and back end
//
// usage
// - input channel in_valid/in_ready carries one raw_sample word; the front end
//   finds the highest breakpoint not above it and classifies the word as below
//   the table, above the table or interpolated
// - output channel out_valid/out_ready carries scaled_value (signed q16.16) and
//   region for every input word, in order
// - the calibration table is written through cfg_write/cfg_index/cfg_data,
//   one breakpoint per write, raw value in the top 16 bits; indexes past the
//   table are ignored; write only while no word is in flight
// - throughput: one word per cycle while the back end is not frozen; the divider
//   is a 48-stage pipeline giving one quotient bit per stage, so the span
//   division never holds up a word
// - a 4-word queue sits between front and back; when out_ready is low while a
//   finished word is held, the back end freezes with that word held, the queue
//   fills and in_ready drops once it is full
// - reset clears the table to zero, empties the queue and drops all valid bits
`default_nettype none

module piecewise_linear_scaling_map #(
  parameter int MAP_POINTS = 5,
  localparam int CFG_IDX_W = $clog2(MAP_POINTS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [plsm_pkg::RAW_W-1:0]           raw_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [plsm_pkg::SCALED_W-1:0] scaled_value,
  output logic [1:0]                           region,
  input  logic                                 cfg_write,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [plsm_pkg::CFG_W-1:0]           cfg_data
);

  import plsm_pkg::*;

  localparam int JOB_W = $bits(job_t);

  // calibration table, one breakpoint per register
  map_point_t points [MAP_POINTS];

  // front end result and queue output
  job_t             front_job;
  logic             job_valid;
  logic             job_ready;
  logic [JOB_W-1:0] job_bits;
  region_t          out_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_POINTS; i++) begin
        points[i] <= '0;
      end
    end else if (cfg_write && ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(MAP_POINTS))) begin
      points[cfg_index] <= map_point_t'(cfg_data);
    end
  end

  // bracket search and classification of the incoming word
  plsm_front #(
    .MAP_POINTS (MAP_POINTS)
  ) u_front (
    .raw_sample (raw_sample),
    .points     (points),
    .job        (front_job)
  );

  // decouples acceptance from the arithmetic pipeline
  plsm_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job_bits)
  );

  // interpolation arithmetic and output register
  plsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job_t'(job_bits)),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scaled_value (scaled_value),
    .region       (out_region)
  );

  assign region = out_region;

endmodule

`default_nettype wire

FILE: hdl/plsm_checker.sv
// port-level checks of the scaling map, bound to the top level
`default_nettype none

module plsm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [plsm_pkg::SCALED_W-1:0] scaled_value,
  input logic [1:0]                           region
);

  import plsm_pkg::*;

  // words accepted but not yet delivered
  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scaled_value) && $stable(region))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result word without an accepted input word");

  a_full_queue: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pending >= 8'(QUEUE_DEPTH))
    else $error("input stalled with the queue not full");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind piecewise_linear_scaling_map plsm_checker u_checker (.*);

`default_nettype wire
